// ===== design/mvr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the eased point-to-point mover.
// No dependencies; used by the interfaces, the top level and the checker.
package mvr_pkg;

    // request payloads
    typedef struct packed {
        logic               command;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic [31:0]        now_time;
        logic [15:0]        step_time;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic               done_res;
    } t_res;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EASE_IN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EASE_OUT = 3'd5;

    localparam logic [31:0] DURATION_RST = 32'd65536;
    localparam logic [15:0] EASE_IN_RST  = 16'd6554;
    localparam logic [15:0] EASE_OUT_RST = 16'd64881;

    // -0.1 in Q16.16, as a magnitude offset on the first ramp
    localparam logic [32:0] NEG_TENTH_MAG = 33'd6554;
    localparam logic [16:0] ONE_Q16       = 17'd65536;
    localparam logic [17:0] THREE_Q16     = 18'd196608;
    localparam logic [30:0] ONE_Q30       = 31'h4000_0000;

endpackage

// ===== design/mvr_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels for start and step requests and for results.
// Depends on mvr_pkg for the payload types.
interface mvr_cmd_if;
    logic              valid;
    logic              ready;
    mvr_pkg::t_cmd     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mvr_res_if;
    logic              valid;
    logic              ready;
    mvr_pkg::t_res     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/eased_point_to_point_mover.sv =====
`timescale 1ns / 1ps
// Eased point-to-point mover: sequencer around one shared multiplier, a radix-2
// divider and a bit-pair square root. Depends on mvr_pkg and mvr_if.
//
//  channel  dir  handshake        payload
//  i_cmd    in   valid/ready      command, start_x/y/z, now_time, step_time
//  o_res    out  valid/ready      pos_x/y/z, vel_x/y/z, done_res
//  i_cfg    in   i_cfg_we only    i_cfg_idx, i_cfg_data
//
// One request at a time. A plain step adds a divide for each smoothstep ramp that
// needs one; a start first runs the square root, then up to four divides.
// The divider produces one quotient bit per cycle.
// Reset is synchronous and clears the motion state to zero.
// A finished result sits in the output register; a new request is taken while
// it waits, and a second result waits until the first has gone.
module eased_point_to_point_mover (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mvr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_data,
    mvr_cmd_if.sink                       i_cmd,
    mvr_res_if.source                     o_res
);

    typedef enum logic [4:0] {
        S_IDLE, S_DIFF, S_SQA, S_SQRT, S_DIST, S_DIRI, S_DIV, S_STEP0, S_R1, S_R2,
        S_SM2, S_TT, S_TT2, S_TT3, S_FAC, S_SPD, S_SPD2, S_VEL, S_INC, S_D2A,
        S_CMP, S_FIN, S_OUT
    } t_state;

    typedef enum logic [1:0] {TAG_AVG, TAG_DIR, TAG_SM1, TAG_SM2} t_tag;

    function automatic logic [31:0] f_dmag(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        logic [32:0] nd;
        d  = {a[31], a} - {b[31], b};
        nd = -d;
        return d[32] ? nd[31:0] : d[31:0];
    endfunction

    function automatic logic [31:0] f_abs(input logic [31:0] v);
        logic [31:0] nv;
        nv = -v;
        return v[31] ? nv : v;
    endfunction

    // configuration
    logic [31:0] r_tgt [3];
    logic [31:0] r_dur;
    logic [15:0] r_ein, r_eout;

    // motion state
    logic [31:0] r_pos [3];
    logic [31:0] r_ud [3];
    logic [31:0] r_avg, r_tstart;
    logic        r_fin;

    // request latch and working registers
    t_state      r_state;
    t_tag        r_tag;
    logic [2:0]  r_idx;
    logic        r_sel;
    logic [31:0] r_now;
    logic [15:0] r_dt;
    logic [31:0] r_m [3];
    logic        r_neg [3];
    logic        r_big;
    logic [32:0] r_dist;
    logic [65:0] r_acc, r_acc2;
    logic [31:0] r_el, r_r1, r_r2, r_speed;
    logic [16:0] r_t, r_s1, r_s2;
    logic [31:0] r_vel [3];
    logic [31:0] r_next [3];

    // shared multiplier
    logic [32:0] r_ma;
    logic [31:0] r_mb;
    logic [64:0] w_prod;

    // divider
    logic [63:0] r_dvd, r_quo;
    logic [32:0] r_rem, r_dvs;
    logic [5:0]  r_cnt;
    logic [33:0] w_rem_sh;
    logic        w_qbit;
    logic [33:0] w_rem_nx;
    logic [63:0] w_quo_nx;

    // square root
    logic [63:0] r_sv, r_sr, r_sb;
    logic [63:0] w_sum;
    logic        w_sge;

    // output register
    logic           r_ovalid;
    mvr_pkg::t_res  r_out;

    // combinational helpers
    logic [32:0] w_sd [3];
    logic [31:0] w_smag [3];
    logic        w_big;
    logic [31:0] w_sq0;
    logic [31:0] w_mn;
    logic [32:0] w_dist;
    logic [30:0] w_q;
    logic [31:0] w_qs;
    logic [32:0] w_n1, w_d1;
    logic [31:0] w_n2, w_d2;
    logic [31:0] w_vm, w_vel, w_vmag;
    logic [30:0] w_inc;
    logic [33:0] w_nsum;
    logic [31:0] w_nsat;
    logic [31:0] w_udm [3];
    logic [31:0] w_sqm [6];
    logic [1:0]  w_k;

    assign w_prod = r_ma * r_mb;

    assign w_rem_sh = {r_rem, r_dvd[63]};
    assign w_qbit   = w_rem_sh >= {1'b0, r_dvs};
    assign w_rem_nx = w_qbit ? (w_rem_sh - {1'b0, r_dvs}) : w_rem_sh;
    assign w_quo_nx = {r_quo[62:0], w_qbit};

    assign w_sum = r_sr + r_sb;
    assign w_sge = r_sv >= w_sum;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sd[k]   = {r_tgt[k][31], r_tgt[k]} - {r_pos[k][31], r_pos[k]};
            w_smag[k] = f_dmag(r_tgt[k], r_pos[k]);
            w_udm[k]  = f_abs(r_ud[k]);
            w_sqm[k]     = f_dmag(r_tgt[k], r_pos[k]);
            w_sqm[k + 3] = f_dmag(r_tgt[k], r_next[k]);
        end
        w_big = w_smag[0][31] | w_smag[1][31] | w_smag[2][31];
        w_sq0 = w_big ? {1'b0, w_smag[0][31:1]} : w_smag[0];
        w_mn  = (r_idx == 3'd0) ? r_m[1] : r_m[2];
        if (r_big) begin
            w_mn = {1'b0, w_mn[31:1]};
        end
        w_dist = r_big ? {r_sr[31:0], 1'b0} : {1'b0, r_sr[31:0]};
        w_q    = (w_quo_nx > {33'd0, mvr_pkg::ONE_Q30}) ? mvr_pkg::ONE_Q30
                                                         : w_quo_nx[30:0];
        w_qs   = r_neg[r_idx[1:0]] ? (-{1'b0, w_q}) : {1'b0, w_q};
        w_n1   = {1'b0, r_el} + mvr_pkg::NEG_TENTH_MAG;
        w_d1   = {1'b0, r_r1} + mvr_pkg::NEG_TENTH_MAG;
        w_n2   = r_el - r_r2;
        w_d2   = r_dur - r_r2;
        // velocity: |ud| * speed >> 30, signed saturation
        w_vm = w_prod[61:30];
        if (r_ud[r_idx[1:0]][31]) begin
            w_vel = (w_vm > 32'h8000_0000) ? 32'h8000_0000 : (-w_vm);
        end else begin
            w_vel = w_vm[31] ? 32'h7FFF_FFFF : w_vm;
        end
        w_vmag = f_abs(w_vel);
        // position: pos + vel * dt >> 16, truncated toward zero, saturated
        w_inc  = w_prod[46:16];
        w_nsum = {{2{r_pos[r_idx[1:0]][31]}}, r_pos[r_idx[1:0]]} +
                 (r_vel[r_idx[1:0]][31] ? (-{3'b0, w_inc}) : {3'b0, w_inc});
        if (w_nsum[33:31] == 3'b000 || w_nsum[33:31] == 3'b111) begin
            w_nsat = w_nsum[31:0];
        end else begin
            w_nsat = w_nsum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        w_k = r_idx[1:0] + 2'd1;
    end

    // configuration writes; a zero ease fraction is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt[0] <= '0;
            r_tgt[1] <= '0;
            r_tgt[2] <= '0;
            r_dur    <= mvr_pkg::DURATION_RST;
            r_ein    <= mvr_pkg::EASE_IN_RST;
            r_eout   <= mvr_pkg::EASE_OUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mvr_pkg::CFG_TARGET_X: r_tgt[0] <= i_cfg_data;
                mvr_pkg::CFG_TARGET_Y: r_tgt[1] <= i_cfg_data;
                mvr_pkg::CFG_TARGET_Z: r_tgt[2] <= i_cfg_data;
                mvr_pkg::CFG_DURATION: r_dur    <= i_cfg_data;
                mvr_pkg::CFG_EASE_IN: begin
                    if (i_cfg_data[15:0] != 16'd0) r_ein <= i_cfg_data[15:0];
                end
                mvr_pkg::CFG_EASE_OUT: begin
                    if (i_cfg_data[15:0] != 16'd0) r_eout <= i_cfg_data[15:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_fin    <= 1'b0;
            r_avg    <= '0;
            r_tstart <= '0;
            for (int k = 0; k < 3; k++) begin
                r_pos[k] <= '0;
                r_ud[k]  <= '0;
            end
        end else begin
            // S_OUT handles the output register itself
            if (r_ovalid && o_res.ready && r_state != S_OUT) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_now <= i_cmd.data.now_time;
                        r_dt  <= i_cmd.data.step_time;
                        if (i_cmd.data.command == mvr_pkg::CMD_START) begin
                            r_pos[0] <= i_cmd.data.start_x;
                            r_pos[1] <= i_cmd.data.start_y;
                            r_pos[2] <= i_cmd.data.start_z;
                            r_state  <= S_DIFF;
                        end else begin
                            r_state  <= S_STEP0;
                        end
                    end
                end
                S_DIFF: begin
                    for (int k = 0; k < 3; k++) begin
                        r_m[k]   <= w_smag[k];
                        r_neg[k] <= w_sd[k][32];
                    end
                    r_big    <= w_big;
                    r_tstart <= r_now;
                    r_fin    <= 1'b0;
                    r_acc    <= '0;
                    r_idx    <= 3'd0;
                    r_ma     <= {1'b0, w_sq0};
                    r_mb     <= w_sq0;
                    r_state  <= S_SQA;
                end
                S_SQA: begin
                    r_acc <= r_acc + {2'b0, w_prod[63:0]};
                    if (r_idx == 3'd2) begin
                        r_sv    <= r_acc[63:0] + w_prod[63:0];
                        r_sr    <= '0;
                        r_sb    <= 64'h4000_0000_0000_0000;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                        r_ma  <= {1'b0, w_mn};
                        r_mb  <= w_mn;
                    end
                end
                S_SQRT: begin
                    if (w_sge) begin
                        r_sv <= r_sv - w_sum;
                        r_sr <= (r_sr >> 1) + r_sb;
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                    r_sb  <= r_sb >> 2;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) r_state <= S_DIST;
                end
                S_DIST: begin
                    r_dist <= w_dist;
                    r_idx  <= 3'd0;
                    if (r_dur == 32'd0) begin
                        r_avg   <= (w_dist != 33'd0) ? 32'hFFFF_FFFF : 32'd0;
                        r_state <= S_DIRI;
                    end else begin
                        r_dvd   <= {15'b0, w_dist, 16'b0};
                        r_dvs   <= {1'b0, r_dur};
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_tag   <= TAG_AVG;
                        r_state <= S_DIV;
                    end
                end
                S_DIRI: begin
                    if (r_dist == 33'd0) begin
                        r_ud[r_idx[1:0]] <= '0;
                        if (r_idx == 3'd2) r_state <= S_STEP0;
                        else r_idx <= r_idx + 3'd1;
                    end else begin
                        r_dvd   <= {2'b0, r_m[r_idx[1:0]], 30'b0};
                        r_dvs   <= r_dist;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_tag   <= TAG_DIR;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_rem_nx[32:0];
                    r_quo <= w_quo_nx;
                    r_dvd <= {r_dvd[62:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        case (r_tag)
                            TAG_AVG: begin
                                r_avg   <= (w_quo_nx[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                                      : w_quo_nx[31:0];
                                r_state <= S_DIRI;
                            end
                            TAG_DIR: begin
                                r_ud[r_idx[1:0]] <= w_qs;
                                if (r_idx == 3'd2) begin
                                    r_state <= S_STEP0;
                                end else begin
                                    r_idx   <= r_idx + 3'd1;
                                    r_state <= S_DIRI;
                                end
                            end
                            default: begin
                                r_t     <= w_quo_nx[16:0];
                                r_state <= S_TT;
                            end
                        endcase
                    end
                end
                S_STEP0: begin
                    if (r_fin) begin
                        for (int k = 0; k < 3; k++) r_vel[k] <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_el    <= (r_now >= r_tstart) ? (r_now - r_tstart) : 32'd0;
                        r_ma    <= {17'b0, r_ein};
                        r_mb    <= r_dur;
                        r_state <= S_R1;
                    end
                end
                S_R1: begin
                    r_r1    <= w_prod[47:16];
                    r_ma    <= {17'b0, r_eout};
                    r_mb    <= r_dur;
                    r_state <= S_R2;
                end
                S_R2: begin
                    // acceleration ramp from -0.1 to ease_in * duration
                    r_r2  <= w_prod[47:16];
                    r_sel <= 1'b0;
                    if (w_n1 >= w_d1) begin
                        r_t     <= mvr_pkg::ONE_Q16;
                        r_state <= S_TT;
                    end else begin
                        r_dvd   <= {15'b0, w_n1, 16'b0};
                        r_dvs   <= w_d1;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_tag   <= TAG_SM1;
                        r_state <= S_DIV;
                    end
                end
                S_SM2: begin
                    // deceleration ramp; empty ramp is a step at the end
                    r_sel <= 1'b1;
                    if (r_dur <= r_r2) begin
                        r_s2    <= (r_el >= r_dur) ? mvr_pkg::ONE_Q16 : 17'd0;
                        r_state <= S_FAC;
                    end else if (r_el <= r_r2) begin
                        r_t     <= '0;
                        r_state <= S_TT;
                    end else if (w_n2 >= w_d2) begin
                        r_t     <= mvr_pkg::ONE_Q16;
                        r_state <= S_TT;
                    end else begin
                        r_dvd   <= {16'b0, w_n2, 16'b0};
                        r_dvs   <= {1'b0, w_d2};
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_tag   <= TAG_SM2;
                        r_state <= S_DIV;
                    end
                end
                S_TT: begin
                    r_ma    <= {16'b0, r_t};
                    r_mb    <= {15'b0, r_t};
                    r_state <= S_TT2;
                end
                S_TT2: begin
                    r_ma    <= w_prod[32:0];
                    r_mb    <= {14'b0, mvr_pkg::THREE_Q16 - {r_t, 1'b0}};
                    r_state <= S_TT3;
                end
                S_TT3: begin
                    if (!r_sel) begin
                        r_s1    <= w_prod[48:32];
                        r_state <= S_SM2;
                    end else begin
                        r_s2    <= w_prod[48:32];
                        r_state <= S_FAC;
                    end
                end
                S_FAC: begin
                    r_ma    <= {16'b0, r_s1};
                    r_mb    <= {15'b0, mvr_pkg::ONE_Q16 - r_s2};
                    r_state <= S_SPD;
                end
                S_SPD: begin
                    r_ma    <= {16'b0, w_prod[32:16]};
                    r_mb    <= r_avg;
                    r_state <= S_SPD2;
                end
                S_SPD2: begin
                    r_speed <= w_prod[47:16];
                    r_idx   <= 3'd0;
                    r_ma    <= {1'b0, w_udm[0]};
                    r_mb    <= w_prod[47:16];
                    r_state <= S_VEL;
                end
                S_VEL: begin
                    r_vel[r_idx[1:0]] <= w_vel;
                    r_ma    <= {1'b0, w_vmag};
                    r_mb    <= {16'b0, r_dt};
                    r_state <= S_INC;
                end
                S_INC: begin
                    r_next[r_idx[1:0]] <= w_nsat;
                    if (r_idx == 3'd2) begin
                        r_idx   <= 3'd0;
                        r_acc   <= '0;
                        r_acc2  <= '0;
                        r_ma    <= {1'b0, w_sqm[0]};
                        r_mb    <= w_sqm[0];
                        r_state <= S_D2A;
                    end else begin
                        r_idx   <= r_idx + 3'd1;
                        r_ma    <= {1'b0, w_udm[w_k]};
                        r_mb    <= r_speed;
                        r_state <= S_VEL;
                    end
                end
                S_D2A: begin
                    // squared distance before (acc) and after (acc2) the move
                    if (r_idx < 3'd3) r_acc  <= r_acc  + {2'b0, w_prod[63:0]};
                    else              r_acc2 <= r_acc2 + {2'b0, w_prod[63:0]};
                    if (r_idx == 3'd5) begin
                        r_state <= S_CMP;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                        r_ma  <= {1'b0, w_sqm[r_idx + 3'd1]};
                        r_mb  <= w_sqm[r_idx + 3'd1];
                    end
                end
                S_CMP: begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_acc2 > r_acc) begin
                            r_pos[k] <= r_tgt[k];
                            r_vel[k] <= '0;
                        end else begin
                            r_pos[k] <= r_next[k];
                        end
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if ((r_pos[0] == r_tgt[0] && r_pos[1] == r_tgt[1] &&
                         r_pos[2] == r_tgt[2]) || r_el >= r_dur) begin
                        r_fin <= 1'b1;
                        for (int k = 0; k < 3; k++) r_vel[k] <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_out.pos_x    <= r_pos[0];
                        r_out.pos_y    <= r_pos[1];
                        r_out.pos_z    <= r_pos[2];
                        r_out.vel_x    <= r_vel[0];
                        r_out.vel_y    <= r_vel[1];
                        r_out.vel_z    <= r_vel[2];
                        r_out.done_res <= r_fin;
                        r_ovalid       <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_out;

endmodule

// ===== design/mvr_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the eased point-to-point mover, bound to the top level.
// Depends on mvr_pkg for the result type.
module mvr_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input mvr_pkg::t_res i_out_data
);

    // one request in flight: ready drops straight after a request is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while busy");

    // no result can appear the cycle after a request
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result too early");

    // a finished move never reports motion
    a_done_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.done_res) |->
        (i_out_data.vel_x == 32'sd0 && i_out_data.vel_y == 32'sd0 &&
         i_out_data.vel_z == 32'sd0))
        else $error("velocity after done");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");

endmodule

bind eased_point_to_point_mover mvr_chk u_mvr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);
